FILE: hw/rtl/mfq_pkg.sv
package mfq_pkg;

  localparam int unsigned BASE_W     = 8;
  localparam int unsigned SLICE_W    = 11;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned PID_W      = 6;
  localparam int unsigned LVL_OUT_W  = 2;
  localparam int unsigned CNT_OUT_W  = 7;
  localparam int unsigned IN_W       = 8;
  localparam int unsigned OUT_W      = 32;

  localparam logic [BASE_W-1:0]  BASE_RESET = 8'd5;
  localparam logic [SLICE_W-1:0] SLICE_MAX  = 11'd2047;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_TICK = 2'd2,
    OP_BAD  = 2'd3
  } op_e;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/mfq_ram.sv
module mfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mfq_ctrl.sv
module mfq_ctrl
  import mfq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/mfq_dp.sv
module mfq_dp
  import mfq_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = 4,
  parameter int unsigned NUM_PROCS  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic              cfg_we_i,
  input  logic [BASE_W-1:0] cfg_data_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  output logic [OUT_W-1:0]  out_data_o
);

  localparam int unsigned PW   = $clog2(NUM_PROCS);
  localparam int unsigned LKW  = PW + 1;
  localparam int unsigned LVW  = $clog2(NUM_LEVELS);
  localparam int unsigned CNTW = $clog2(NUM_PROCS + 1);
  localparam int unsigned CAPW = SLICE_W + NUM_LEVELS;
  localparam int unsigned STW  = 1 + LVW + SLICE_W;

  localparam logic [LKW-1:0] LINK_NULL = LKW'(NUM_PROCS);
  localparam logic [LVW-1:0] LV_TOP    = LVW'(NUM_LEVELS - 1);
  localparam logic [PW-1:0]  CLR_LAST  = PW'(NUM_PROCS - 1);

  logic [BASE_W-1:0]  base_q;
  op_e                op_q;
  logic [PW-1:0]      idx_q;
  logic               pid_ok_q;
  logic [PW-1:0]      clr_q;
  logic [LKW-1:0]     head_q [NUM_LEVELS];
  logic [LKW-1:0]     tail_q [NUM_LEVELS];
  logic [CNTW-1:0]    cnt_q;
  logic               err_q;
  logic               resched_q;
  logic [SLICE_W-1:0] slice_res_q;
  logic [LVW-1:0]     lvl_res_q;
  logic               enq_ok_q;
  logic [OUT_W-1:0]   out_q;

  logic [PID_W-1:0]   in_pid;
  logic [PW-1:0]      in_idx;
  op_e                in_op;

  logic               st_we;
  logic [PW-1:0]      st_waddr;
  logic [STW-1:0]     st_wdata;
  logic [STW-1:0]     st_rdata;
  logic               nx_we;
  logic [PW-1:0]      nx_waddr;
  logic [LKW-1:0]     nx_wdata;
  logic [LKW-1:0]     nx_rdata;
  logic               pv_we;
  logic [PW-1:0]      pv_waddr;
  logic [LKW-1:0]     pv_wdata;
  logic [LKW-1:0]     pv_rdata;

  logic               st_queued;
  logic [LVW-1:0]     st_lv;
  logic [SLICE_W-1:0] st_slice;
  logic [LVW-1:0]     lv_n;
  logic [CAPW-1:0]    cap_wide;
  logic [SLICE_W-1:0] cap;
  logic [SLICE_W-1:0] slc_n;
  logic [SLICE_W-1:0] dec;
  logic [LKW-1:0]     tl;
  logic [LKW-1:0]     self_link;
  logic               enq_ok;
  logic               deq_ok;
  logic               tick_ok;
  logic               err;
  logic               nvalid;
  logic [LKW-1:0]     npid;

  assign in_op    = op_e'(in_data_i[OP_W-1:0]);
  assign in_pid   = in_data_i[OP_W +: PID_W];
  assign in_idx   = PW'(in_pid);

  assign st_queued = st_rdata[STW-1];
  assign st_lv     = st_rdata[SLICE_W +: LVW];
  assign st_slice  = st_rdata[SLICE_W-1:0];

  assign lv_n     = (st_slice == '0 && st_lv < LV_TOP) ? st_lv + LVW'(1) : st_lv;
  assign cap_wide = CAPW'(base_q) << lv_n;
  assign cap      = (cap_wide > CAPW'(SLICE_MAX)) ? SLICE_MAX : cap_wide[SLICE_W-1:0];
  assign slc_n    = (st_slice == '0 || st_slice > cap) ? cap : st_slice;
  assign dec      = (st_slice != '0) ? st_slice - SLICE_W'(1) : st_slice;
  assign tl       = tail_q[lv_n];
  assign self_link = {1'b0, idx_q};

  assign enq_ok  = pid_ok_q && (op_q == OP_ENQ) && !st_queued;
  assign deq_ok  = pid_ok_q && (op_q == OP_DEQ) && st_queued;
  assign tick_ok = pid_ok_q && (op_q == OP_TICK);
  assign err     = !pid_ok_q || (op_q == OP_BAD) ||
                   (op_q == OP_ENQ && st_queued) || (op_q == OP_DEQ && !st_queued);

  always_comb begin
    st_we    = cmd_i.clr_wr || (cmd_i.exec && (enq_ok || deq_ok || tick_ok));
    st_waddr = cmd_i.clr_wr ? clr_q : idx_q;
    if (cmd_i.clr_wr) begin
      st_wdata = '0;
    end else if (enq_ok) begin
      st_wdata = {1'b1, lv_n, slc_n};
    end else if (deq_ok) begin
      st_wdata = {1'b0, st_lv, st_slice};
    end else begin
      st_wdata = {st_queued, st_lv, dec};
    end
  end

  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = idx_q;
    nx_wdata = LINK_NULL;
    if (cmd_i.exec && enq_ok && tl != LINK_NULL) begin
      nx_we    = 1'b1;
      nx_waddr = tl[PW-1:0];
      nx_wdata = self_link;
    end else if (cmd_i.exec && deq_ok && pv_rdata != LINK_NULL) begin
      nx_we    = 1'b1;
      nx_waddr = pv_rdata[PW-1:0];
      nx_wdata = nx_rdata;
    end else if (cmd_i.load && enq_ok_q) begin
      nx_we    = 1'b1;
    end
  end

  always_comb begin
    pv_we    = 1'b0;
    pv_waddr = idx_q;
    pv_wdata = tl;
    if (cmd_i.exec && enq_ok) begin
      pv_we    = 1'b1;
    end else if (cmd_i.exec && deq_ok && nx_rdata != LINK_NULL) begin
      pv_we    = 1'b1;
      pv_waddr = nx_rdata[PW-1:0];
      pv_wdata = pv_rdata;
    end
  end

  mfq_ram #(.WIDTH(STW), .DEPTH(NUM_PROCS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (in_idx),
    .rdata_o (st_rdata)
  );

  mfq_ram #(.WIDTH(LKW), .DEPTH(NUM_PROCS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (in_idx),
    .rdata_o (nx_rdata)
  );

  mfq_ram #(.WIDTH(LKW), .DEPTH(NUM_PROCS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .raddr_i (in_idx),
    .rdata_o (pv_rdata)
  );

  always_comb begin
    nvalid = 1'b0;
    npid   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (head_q[i] != LINK_NULL) begin
        nvalid = 1'b1;
        npid   = head_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      clr_q  <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= LINK_NULL;
        tail_q[i] <= LINK_NULL;
      end
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + PW'(1);
      end
      if (cmd_i.exec && enq_ok) begin
        if (tl == LINK_NULL) begin
          head_q[lv_n] <= self_link;
        end
        tail_q[lv_n] <= self_link;
        cnt_q        <= cnt_q + CNTW'(1);
      end else if (cmd_i.exec && deq_ok) begin
        if (pv_rdata == LINK_NULL) begin
          head_q[st_lv] <= nx_rdata;
        end
        if (nx_rdata == LINK_NULL) begin
          tail_q[st_lv] <= pv_rdata;
        end
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_op;
      idx_q    <= in_idx;
      pid_ok_q <= (32'(in_pid) < NUM_PROCS);
    end
    if (cmd_i.exec) begin
      err_q     <= err;
      resched_q <= tick_ok && (dec == '0);
      enq_ok_q  <= enq_ok;
      if (!pid_ok_q) begin
        slice_res_q <= '0;
        lvl_res_q   <= '0;
      end else if (enq_ok) begin
        slice_res_q <= slc_n;
        lvl_res_q   <= lv_n;
      end else if (tick_ok) begin
        slice_res_q <= dec;
        lvl_res_q   <= st_lv;
      end else begin
        slice_res_q <= st_slice;
        lvl_res_q   <= st_lv;
      end
    end
    if (cmd_i.load) begin
      out_q <= {3'b000, err_q, CNT_OUT_W'(cnt_q), LVL_OUT_W'(lvl_res_q), slice_res_q,
                resched_q, PID_W'(npid), nvalid};
    end
  end

  assign stat_o.clr_last = (clr_q == CLR_LAST);
  assign out_data_o      = out_q;

endmodule

FILE: hw/rtl/multilevel_feedback_queue_scheduler_top.sv
// Multilevel feedback queue scheduler. Each request (opcode, pid) enqueues,
// dequeues or ticks one process, or flags op_error, and returns one result
// with the head of the highest-priority nonempty level, the queued count and
// the addressed process's slice and level. An accepted request passes through
// a registered read of the per-process memories, then the update of links
// and level pointers, then the load of the result into the output register;
// the next request is taken only after that load. A result held by a low
// m_axis_tready_i keeps the following request from loading its result, and
// no further request is taken meanwhile.
// After reset a clearing pass zeroes the per-process state memory; no request
// is accepted during it, configuration writes are.
module multilevel_feedback_queue_scheduler_top
  import mfq_pkg::*;
#(
  parameter int unsigned NUM_LEVELS = 4,
  parameter int unsigned NUM_PROCS  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // opcode[1:0], pid[7:2]
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // next_valid[0], next_pid[6:1], resched_req[7], slice_left[18:8],
  // proc_level[20:19], queued_count[27:21], op_error[28], zero[31:29]
  output logic [OUT_W-1:0]  m_axis_tdata_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [BASE_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  mfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mfq_dp #(
    .NUM_LEVELS (NUM_LEVELS),
    .NUM_PROCS  (NUM_PROCS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

FILE: hw/rtl/mfq_checker.sv
module mfq_checker
  import mfq_pkg::*;
#(
  parameter int unsigned NUM_PROCS = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid_i,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  a_next_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> (m_axis_tdata_i[0] == (m_axis_tdata_i[27:21] != 7'd0)))
    else $error("next_valid disagrees with queued_count");

  a_empty_pid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tdata_i[0] |-> m_axis_tdata_i[6:1] == 6'd0)
    else $error("next_pid nonzero with no queued process");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> 32'(m_axis_tdata_i[27:21]) <= NUM_PROCS)
    else $error("queued_count above process count");

  a_resched_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[7] |-> m_axis_tdata_i[18:8] == 11'd0 &&
                                              !m_axis_tdata_i[28])
    else $error("reschedule with slice left or on an error");

endmodule

bind multilevel_feedback_queue_scheduler_top mfq_checker #(
  .NUM_PROCS (NUM_PROCS)
) u_mfq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
